// File: design/swm_pkg.sv
`default_nettype none
package swm_pkg;

  localparam int unsigned WINDOW   = 10;
  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned OUT_W    = SAMPLE_W + 1;
  localparam int unsigned AGE_W    = $clog2(WINDOW);
  localparam int unsigned LO_IDX   = (WINDOW - 1) / 2;
  localparam int unsigned HI_IDX   = WINDOW / 2;
  localparam logic [AGE_W-1:0] OLDEST_AGE = AGE_W'(WINDOW - 1);

  // contents of one cell as seen by its neighbors
  typedef struct packed {
    logic                       valid;
    logic                       le;     // valid and value <= incoming sample
    logic signed [SAMPLE_W-1:0] value;
    logic [AGE_W-1:0]           age;
  } swm_cell_t;

  // left-to-right link between cells
  typedef struct packed {
    logic ale;   // entry at this place after eviction is <= incoming sample
    logic dpre;  // evicted entry sits at or left of this place
  } swm_link_t;

endpackage
`default_nettype wire

// File: design/swm_cell.sv
`default_nettype none
module swm_cell (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               load_i,
  input  wire logic                               full_i,
  input  wire logic signed [swm_pkg::SAMPLE_W-1:0] sample_i,
  input  wire swm_pkg::swm_cell_t                 left_state_i,
  input  wire swm_pkg::swm_link_t                 left_link_i,
  input  wire swm_pkg::swm_cell_t                 right_state_i,
  output swm_pkg::swm_cell_t                      state_o,
  output swm_pkg::swm_link_t                      link_o
);
  import swm_pkg::*;

  logic                       valid_q, valid_d;
  logic signed [SAMPLE_W-1:0] value_q, value_d;
  logic [AGE_W-1:0]           age_q, age_d;

  logic      del;
  swm_cell_t self_s;
  swm_cell_t a_cur;   // entry at this place after eviction
  swm_cell_t a_prev;  // entry at the left place after eviction

  always_comb begin
    self_s.valid = valid_q;
    self_s.le    = valid_q && (value_q <= sample_i);
    self_s.value = value_q;
    self_s.age   = age_q;
  end

  assign del         = full_i && valid_q && (age_q == OLDEST_AGE);
  assign link_o.dpre = left_link_i.dpre | del;
  assign a_cur       = link_o.dpre ? right_state_i : self_s;
  assign a_prev      = left_link_i.dpre ? self_s : left_state_i;
  assign link_o.ale  = a_cur.le;
  assign state_o     = self_s;

  always_comb begin
    if (a_cur.le) begin
      valid_d = a_cur.valid;
      value_d = a_cur.value;
      age_d   = a_cur.age + AGE_W'(1);
    end else if (left_link_i.ale) begin
      valid_d = 1'b1;
      value_d = sample_i;
      age_d   = '0;
    end else begin
      valid_d = a_prev.valid;
      value_d = a_prev.value;
      age_d   = a_prev.age + AGE_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      value_q <= value_d;
      age_q   <= age_d;
    end
  end

endmodule
`default_nettype wire

// File: design/sliding_window_median.sv
// Sliding window median filter.
// Input channel: sample_i (signed 32-bit, 8 fraction bits) with sample_valid_i;
// a request is taken at a clock edge where sample_valid_i is high and
// sample_stall_o is low.
// Output channel: median_x2_o (signed 33-bit, twice the window median) with
// median_valid_o; the downstream side holds it with median_stall_i.
// The window is a row of WINDOW cells kept in sorted order; each request inserts
// the new sample and, once the window is full, evicts the oldest entry in the same update.
// No result is produced for the first WINDOW-1 requests after reset; every
// later request yields exactly one result.
// The sorted cells are registered first; the middle-pair sum then goes into
// the output register once that register is free.
// Throughput: one request per cycle while the output is not stalled.
// Reset empties the window and drops any pending result.
// When median_stall_i holds a result, one more request can be sorted in; after
// that sample_stall_o rises until the output register frees up.
`default_nettype none
module sliding_window_median (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic signed [swm_pkg::SAMPLE_W-1:0] sample_i,
  input  wire logic                                sample_valid_i,
  output logic                                     sample_stall_o,
  output logic signed [swm_pkg::OUT_W-1:0]         median_x2_o,
  output logic                                     median_valid_o,
  input  wire logic                                median_stall_i
);
  import swm_pkg::*;

  swm_cell_t cell_state [WINDOW];
  swm_link_t cell_link  [WINDOW];
  swm_cell_t left_state [WINDOW];
  swm_link_t left_link  [WINDOW];
  swm_cell_t right_state[WINDOW];

  logic load, full, emit, out_free;
  logic pend_q, out_valid_q;
  logic signed [OUT_W-1:0] median_q, median_d;

  assign full     = cell_state[WINDOW-1].valid;
  assign emit     = cell_state[WINDOW-2].valid;
  assign out_free = !out_valid_q || !median_stall_i;
  assign sample_stall_o = pend_q && !out_free;
  assign load     = sample_valid_i && !sample_stall_o;

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_state[i] = '0;
      assign left_link[i]  = '{ale: 1'b1, dpre: 1'b0};
    end else begin : g_mid
      assign left_state[i] = cell_state[i-1];
      assign left_link[i]  = cell_link[i-1];
    end
    if (i == WINDOW - 1) begin : g_last
      assign right_state[i] = '0;
    end else begin : g_body
      assign right_state[i] = cell_state[i+1];
    end

    swm_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .load_i        (load),
      .full_i        (full),
      .sample_i      (sample_i),
      .left_state_i  (left_state[i]),
      .left_link_i   (left_link[i]),
      .right_state_i (right_state[i]),
      .state_o       (cell_state[i]),
      .link_o        (cell_link[i])
    );
  end

  assign median_d = OUT_W'(cell_state[LO_IDX].value) + OUT_W'(cell_state[HI_IDX].value);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid_q <= pend_q;
      end
      if (load) begin
        pend_q <= emit;
      end else if (out_free) begin
        pend_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_q && out_free) begin
      median_q <= median_d;
    end
  end

  assign median_x2_o    = median_q;
  assign median_valid_o = out_valid_q;

endmodule
`default_nettype wire

// File: design/swm_checker.sv
`default_nettype none
module swm_checker (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                sample_valid_i,
  input wire logic                                sample_stall_o,
  input wire logic signed [swm_pkg::OUT_W-1:0]    median_x2_o,
  input wire logic                                median_valid_o,
  input wire logic                                median_stall_i
);
  logic in_acc;
  assign in_acc = sample_valid_i && !sample_stall_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    median_valid_o && median_stall_i |=> median_valid_o && $stable(median_x2_o))
    else $error("stalled result changed");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_stall_o |-> median_valid_o && median_stall_i)
    else $error("input stalled without a held result");

  a_rise_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(median_valid_o) |-> $past(in_acc, 2))
    else $error("result appeared without a request two cycles earlier");

  a_no_ghost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(in_acc) && !$past(in_acc, 2) && !$past(median_valid_o) |-> !median_valid_o)
    else $error("result without request");

endmodule

bind sliding_window_median swm_checker u_swm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .sample_valid_i (sample_valid_i),
  .sample_stall_o (sample_stall_o),
  .median_x2_o    (median_x2_o),
  .median_valid_o (median_valid_o),
  .median_stall_i (median_stall_i)
);
`default_nettype wire
